FILE: rtl/core/gdd_pkg.sv
// shared types, constants and the month length decoder for the date difference block
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    // running year holds one more bit: stepping may move one year past the input range
    localparam int CUR_YEAR_W = YEAR_W + 1;
    localparam int PREP_W     = 1;

    // floor(y / 25) = (y * 20972) >> 19, exact for every 14-bit year
    localparam int          RECIP25_SHIFT = 19;
    localparam logic [14:0] RECIP25       = 15'd20972;
    localparam int          Q25_W         = 10;

    localparam int YEAR_MAX_DEF = 9999;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [4:0]         MOD25     = 5'd25;
    localparam logic [4:0]         MOD25_TOP = 5'd24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic check;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic prep_last;
        logic invalid;
        logic running;
    } t_dp_sts;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/gdd_if.sv
// valid/ready channel interfaces for date input and day count output
`timescale 1ns / 1ps

interface gdd_in_if;
    logic                          valid;
    logic                          ready;
    logic [gdd_pkg::DAY_W-1:0]     start_day;
    logic [gdd_pkg::MONTH_W-1:0]   start_month;
    logic [gdd_pkg::YEAR_W-1:0]    start_year;
    logic [gdd_pkg::DAY_W-1:0]     end_day;
    logic [gdd_pkg::MONTH_W-1:0]   end_month;
    logic [gdd_pkg::YEAR_W-1:0]    end_year;
    logic                          include_end;

    modport source (
        output valid, start_day, start_month, start_year,
        output end_day, end_month, end_year, include_end,
        input  ready
    );
    modport sink (
        input  valid, start_day, start_month, start_year,
        input  end_day, end_month, end_year, include_end,
        output ready
    );
endinterface

interface gdd_out_if;
    logic                          valid;
    logic                          ready;
    logic [gdd_pkg::COUNT_W-1:0]   day_count;
    logic                          invalid_start;

    modport source (output valid, day_count, invalid_start, input ready);
    modport sink   (input valid, day_count, invalid_start, output ready);
endinterface

FILE: rtl/core/gdd_datapath.sv
// date registers, leap logic, mod 25 unit, day stepper and result register
`timescale 1ns / 1ps

module gdd_datapath #(
    parameter int YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
    input  logic                              i_clk,
    input  gdd_pkg::t_dp_cmd                  i_cmd,
    input  logic [gdd_pkg::DAY_W-1:0]         i_start_day,
    input  logic [gdd_pkg::MONTH_W-1:0]       i_start_month,
    input  logic [gdd_pkg::YEAR_W-1:0]        i_start_year,
    input  logic [gdd_pkg::DAY_W-1:0]         i_end_day,
    input  logic [gdd_pkg::MONTH_W-1:0]       i_end_month,
    input  logic [gdd_pkg::YEAR_W-1:0]        i_end_year,
    input  logic                              i_include_end,
    output gdd_pkg::t_dp_sts                  o_sts,
    output logic [gdd_pkg::COUNT_W-1:0]       o_day_count,
    output logic                              o_invalid_start
);

    localparam logic [16:0] YearMaxW   = 17'(YEAR_MAX);
    localparam logic [16:0] YearClampW = 17'(YEAR_MAX + 1);

    logic [gdd_pkg::DAY_W-1:0]      r_day, n_day;
    logic [gdd_pkg::MONTH_W-1:0]    r_mon, n_mon;
    logic [gdd_pkg::CUR_YEAR_W-1:0] r_year, n_year;
    logic [4:0]                     r_m25, n_m25;
    logic [gdd_pkg::Q25_W-1:0]      r_q25;
    logic [gdd_pkg::PREP_W-1:0]     r_prep;
    logic [gdd_pkg::DAY_W-1:0]      r_end_day;
    logic [gdd_pkg::MONTH_W-1:0]    r_end_mon;
    logic [gdd_pkg::CUR_YEAR_W-1:0] r_end_year;
    logic                           r_inc;
    logic                           r_bad;
    logic [gdd_pkg::COUNT_W-1:0]    r_count;
    logic [gdd_pkg::COUNT_W-1:0]    r_out_count;
    logic                           r_out_invalid;

    logic [28:0]                    w_prod;
    logic [gdd_pkg::Q25_W-1:0]      w_q25;
    logic [gdd_pkg::CUR_YEAR_W-1:0] w_q25x25;
    logic [gdd_pkg::CUR_YEAR_W-1:0] w_rem;
    logic [4:0]                     w_m25_calc;
    logic                           w_leap;
    logic                           w_cent;
    logic [gdd_pkg::DAY_W-1:0]      w_len;
    logic                           w_before;
    logic                           w_bad;

    // remainder by 25: reciprocal multiply for the quotient, registered, then subtract
    assign w_prod     = 29'(r_year[gdd_pkg::YEAR_W-1:0]) * 29'(gdd_pkg::RECIP25);
    assign w_q25      = w_prod[gdd_pkg::RECIP25_SHIFT +: gdd_pkg::Q25_W];
    assign w_q25x25   = gdd_pkg::CUR_YEAR_W'(r_q25) * gdd_pkg::CUR_YEAR_W'(gdd_pkg::MOD25);
    assign w_rem      = r_year - w_q25x25;
    assign w_m25_calc = w_rem[4:0];

    // divisible by 100 = by 4 and by 25; by 400 = by 16 and by 25
    assign w_cent = (r_year[1:0] == 2'b00) && (r_m25 == 5'd0);
    assign w_leap = ((r_year[1:0] == 2'b00) && !w_cent) ||
                    ((r_year[3:0] == 4'b0000) && (r_m25 == 5'd0));
    assign w_len  = gdd_pkg::month_len(r_mon, w_leap);

    assign w_before = {r_year, r_mon, r_day} < {r_end_year, r_end_mon, r_end_day};

    assign w_bad = (r_mon < gdd_pkg::MONTH_JAN) || (r_mon > gdd_pkg::MONTH_DEC) ||
                   ({2'b00, r_year} > YearMaxW) || (r_day > w_len);

    // next calendar date; day zero moves to the first of the month
    always_comb begin
        n_day  = r_day;
        n_mon  = r_mon;
        n_year = r_year;
        n_m25  = r_m25;
        if (r_day == '0) begin
            n_day = 5'd1;
        end else if (r_day >= w_len) begin
            n_day = 5'd1;
            if (r_mon == gdd_pkg::MONTH_DEC) begin
                n_mon  = gdd_pkg::MONTH_JAN;
                n_year = r_year + 1'b1;
                n_m25  = (r_m25 == gdd_pkg::MOD25_TOP) ? 5'd0 : r_m25 + 1'b1;
            end else begin
                n_mon = r_mon + 1'b1;
            end
        end else begin
            n_day = r_day + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= i_start_day;
            r_mon   <= i_start_month;
            r_year  <= {1'b0, i_start_year};
            r_prep  <= gdd_pkg::PREP_W'(1);
            r_inc   <= i_include_end;
            r_count <= '0;
            // an end year past YEAR_MAX acts as new year's day of year YEAR_MAX + 1
            if ({3'b000, i_end_year} > YearMaxW) begin
                r_end_year <= YearClampW[gdd_pkg::CUR_YEAR_W-1:0];
                r_end_mon  <= gdd_pkg::MONTH_JAN;
                r_end_day  <= 5'd1;
            end else begin
                r_end_year <= {1'b0, i_end_year};
                r_end_mon  <= i_end_month;
                r_end_day  <= i_end_day;
            end
        end
        if (i_cmd.prep) begin
            // the quotient is registered first, then the remainder is taken from the registered quotient
            r_q25  <= w_q25;
            r_m25  <= w_m25_calc;
            r_prep <= r_prep - 1'b1;
        end
        if (i_cmd.check) begin
            r_bad <= w_bad;
        end
        if (i_cmd.step) begin
            r_day   <= n_day;
            r_mon   <= n_mon;
            r_year  <= n_year;
            r_m25   <= n_m25;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_invalid <= r_bad;
            if (r_bad) begin
                r_out_count <= '0;
            end else if (r_count == gdd_pkg::COUNT_LIMIT) begin
                r_out_count <= gdd_pkg::COUNT_LIMIT;
            end else begin
                r_out_count <= r_count + gdd_pkg::COUNT_W'(r_inc);
            end
        end
    end

    assign o_sts.prep_last = (r_prep == '0);
    assign o_sts.invalid   = w_bad;
    assign o_sts.running   = w_before && (r_count != gdd_pkg::COUNT_LIMIT);

    assign o_day_count     = r_out_count;
    assign o_invalid_start = r_out_invalid;

endmodule

FILE: rtl/core/gdd_ctrl.sv
// sequencing state machine and output valid register
`timescale 1ns / 1ps

module gdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  gdd_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output gdd_pkg::t_dp_cmd  o_cmd,
    output gdd_pkg::t_state   o_state
);

    gdd_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            gdd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = gdd_pkg::S_PREP;
                end
            end
            gdd_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.prep_last) begin
                    n_state = gdd_pkg::S_CHECK;
                end
            end
            gdd_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.invalid ? gdd_pkg::S_DONE : gdd_pkg::S_RUN;
            end
            gdd_pkg::S_RUN: begin
                if (i_sts.running) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = gdd_pkg::S_DONE;
                end
            end
            gdd_pkg::S_DONE: begin
                // result register free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = gdd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gdd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

FILE: rtl/core/gregorian_date_day_difference.sv
// top level: day count between two gregorian dates by single-day stepping
`timescale 1ns / 1ps

// channel | dir | fields                                            | transaction
// i_in    | in  | start_day/month/year, end_day/month/year, incl.   | one date pair
// o_out   | out | day_count, invalid_start                          | one result
//
// a transaction passes from acceptance through prep (the year remainder by 25 behind the
// leap test), check, run (stepping until the end date or the count limit) and done
// (the write); an unusable start skips the stepper
// reset is synchronous active low and returns the controller to idle, result empty
// input is taken only in idle and reopens the cycle after the write; a result stalled in
// the output register holds only the final write of the next transaction

module gregorian_date_day_difference #(
    parameter int YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gdd_in_if.sink           i_in,
    gdd_out_if.source        o_out
);

    gdd_pkg::t_dp_cmd w_cmd;
    gdd_pkg::t_dp_sts w_sts;
    gdd_pkg::t_state  w_state;

    gdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    gdd_datapath #(
        .YEAR_MAX (YEAR_MAX)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_cmd           (w_cmd),
        .i_start_day     (i_in.start_day),
        .i_start_month   (i_in.start_month),
        .i_start_year    (i_in.start_year),
        .i_end_day       (i_in.end_day),
        .i_end_month     (i_in.end_month),
        .i_end_year      (i_in.end_year),
        .i_include_end   (i_in.include_end),
        .o_sts           (w_sts),
        .o_day_count     (o_out.day_count),
        .o_invalid_start (o_out.invalid_start)
    );

    // a new transaction closes the input until its result is written
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted again while busy");

    // rejected start dates never carry a count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.invalid_start) |-> (o_out.day_count == '0))
        else $error("invalid start with nonzero count");

    // a fresh result appears exactly as the controller returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (w_state == gdd_pkg::S_IDLE))
        else $error("result written outside completion");

    // the stepper only advances while the start still lies before the end
    a_step_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> (w_state == gdd_pkg::S_RUN) && w_sts.running)
        else $error("date stepped past the end");

endmodule
